// ===== rtl/cwf_pkg.sv =====
// cwf_pkg: shared types and constants of the convective weight pipeline
// no dependencies; used by cwf_exp2_neg, cwf_divider, cwf_power_law and convective_weight_function

package cwf_pkg;

    typedef enum logic [2:0] {
        SCH_ZERO        = 3'd0,
        SCH_CENTRAL     = 3'd1,
        SCH_UPWIND      = 3'd2,
        SCH_HYBRID      = 3'd3,
        SCH_POWER_LAW   = 3'd4,
        SCH_EXPONENTIAL = 3'd5,
        SCH_RATIONAL    = 3'd6,
        SCH_POWER       = 3'd7
    } t_scheme;

    localparam t_scheme SCHEME_RESET = SCH_POWER_LAW;

    localparam int PE_W  = 24;
    localparam int OUT_W = 17;

    localparam logic [16:0] ONE_OUT    = 17'd65536;
    localparam logic [24:0] ONE_Q24    = 25'd16777216;
    localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
    localparam logic [24:0] LOG2E_Q24  = 25'd24204406;
    localparam logic [24:0] NLOG2_0553 = 25'd14338624;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [15:0] K6712_Q16  = 16'd43988;
    // ceil(2^32 / 10): exact quotient for dividends below 2^28
    localparam logic [28:0] RECIP10    = 29'd429496730;

    // input thresholds on the raw Q8.16 magnitude
    localparam logic [23:0] X_ONE       = 24'd65536;
    localparam logic [23:0] X_SMALL_MAX = 24'd655;
    localparam logic [23:0] X_TEN       = 24'd655360;
    localparam logic [23:0] X_SIXTY4    = 24'd4194304;

    // floor(u / k) = (u * RECIP_M[k]) >> RECIP_S[k] for any 32-bit u
    localparam logic [32:0] RECIP_M [1:12] = '{
        33'd4294967297, 33'd4294967297, 33'd5726623062, 33'd4294967297,
        33'd6871947674, 33'd5726623062, 33'd4908534053, 33'd4294967297,
        33'd7635497416, 33'd6871947674, 33'd6247225158, 33'd5726623062
    };
    localparam int RECIP_S [1:12] = '{32, 33, 34, 34, 35, 35, 35, 35, 36, 36, 36, 36};

    localparam int EXP_TERMS = 12;

endpackage

// ===== rtl/cwf_pe_if.sv =====
// cwf_pe_if: valid/ready channel carrying one peclet magnitude per beat
// no dependencies

interface cwf_pe_if;
    logic        valid;
    logic        ready;
    logic [23:0] peclet_magnitude;

    modport source (output valid, output peclet_magnitude, input ready);
    modport sink   (input valid, input peclet_magnitude, output ready);
endinterface

// ===== rtl/cwf_wt_if.sv =====
// cwf_wt_if: valid/ready channel carrying one convection weight per beat
// no dependencies

interface cwf_wt_if;
    logic        valid;
    logic        ready;
    logic [16:0] weight;

    modport source (output valid, output weight, input ready);
    modport sink   (input valid, input weight, output ready);
endinterface

// ===== rtl/cwf_exp2_neg.sv =====
// cwf_exp2_neg: 2^-z in Q.32 for z in Q.32, 26 register stages
// depends on cwf_pkg (series reciprocals, ln2)

module cwf_exp2_neg (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [37:0] i_z,
    output logic [32:0] o_e
);
    import cwf_pkg::*;

    logic [31:0] r_g0;
    logic [5:0]  r_n0;
    logic [63:0] gprod;

    logic [32:0] w_t   [0:EXP_TERMS];
    logic [31:0] w_g   [0:EXP_TERMS];
    logic [5:0]  w_n   [0:EXP_TERMS];
    logic [33:0] w_acc [0:EXP_TERMS];

    logic [32:0] r_e;
    logic [33:0] fin_sh;

    assign gprod = 64'(i_z[31:0]) * 64'(LN2_Q32);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g0 <= gprod[63:32];
            r_n0 <= i_z[37:32];
        end
    end

    assign w_t[0]   = ONE_Q32;
    assign w_g[0]   = r_g0;
    assign w_n[0]   = r_n0;
    assign w_acc[0] = 34'(ONE_Q32);

    // one series term per two stages: multiply by g, then divide by k
    for (genvar k = 1; k <= EXP_TERMS; k++) begin : g_term
        logic [64:0] mprod;
        logic [64:0] dprod;
        logic [64:0] dsh;
        logic [31:0] r_u;
        logic [31:0] r_mg;
        logic [5:0]  r_mn;
        logic [33:0] r_macc;
        logic [32:0] r_t;
        logic [31:0] r_dg;
        logic [5:0]  r_dn;
        logic [33:0] r_dacc;
        logic [33:0] acc_n;

        assign mprod = 65'(w_t[k-1]) * 65'(w_g[k-1]);
        assign dprod = 65'(r_u) * 65'(RECIP_M[k]);
        assign dsh   = dprod >> RECIP_S[k];

        if (k % 2 == 1) begin : g_odd
            assign acc_n = r_macc - {2'b00, dsh[31:0]};
        end else begin : g_even
            assign acc_n = r_macc + {2'b00, dsh[31:0]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_u    <= mprod[63:32];
                r_mg   <= w_g[k-1];
                r_mn   <= w_n[k-1];
                r_macc <= w_acc[k-1];
                r_t    <= {1'b0, dsh[31:0]};
                r_dg   <= r_mg;
                r_dn   <= r_mn;
                r_dacc <= acc_n;
            end
        end

        assign w_t[k]   = r_t;
        assign w_g[k]   = r_dg;
        assign w_n[k]   = r_dn;
        assign w_acc[k] = r_dacc;
    end

    assign fin_sh = w_acc[EXP_TERMS] >> w_n[EXP_TERMS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e <= (w_n[EXP_TERMS] >= 6'd40) ? 33'd0 : fin_sh[32:0];
        end
    end

    assign o_e = r_e;

endmodule

// ===== rtl/cwf_divider.sv =====
// cwf_divider: restoring divider giving the truncated quotient, one quotient bit per stage
// depends on cwf_pkg; 18 register stages, 17 quotient bits plus overflow flag

module cwf_divider (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [61:0] i_num,
    input  logic [48:0] i_den,
    output logic [16:0] o_quo,
    output logic        o_ovf
);
    import cwf_pkg::*;

    logic [61:0] r_rem [0:16];
    logic [48:0] r_den [0:16];
    logic        r_ovf [0:17];
    logic [16:0] r_q   [1:17];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            // quotient would need more than 17 bits
            r_ovf[0] <= {4'b0000, i_num} >= ({17'd0, i_den} << 17);
        end
    end

    for (genvar s = 1; s <= 17; s++) begin : g_step
        logic [65:0] trial;
        logic        ge;
        logic [16:0] q_prev;

        assign trial = {17'd0, r_den[s-1]} << (17 - s);
        assign ge    = {4'b0000, r_rem[s-1]} >= trial;

        if (s == 1) begin : g_first
            assign q_prev = '0;
        end else begin : g_rest
            assign q_prev = r_q[s-1];
        end

        if (s < 17) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= ge ? r_rem[s-1] - trial[61:0] : r_rem[s-1];
                    r_den[s] <= r_den[s-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s]   <= q_prev | (17'(ge) << (17 - s));
                r_ovf[s] <= r_ovf[s-1];
            end
        end
    end

    assign o_quo = r_q[17];
    assign o_ovf = r_ovf[17];

endmodule

// ===== rtl/cwf_power_law.sv =====
// cwf_power_law: (1 - 0.1P)^5 with P below ten, else zero; 4 register stages
// depends on cwf_pkg

module cwf_power_law (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [23:0] i_x,
    output logic [16:0] o_w
);
    import cwf_pkg::*;

    function automatic logic [24:0] mul24(input logic [24:0] a, input logic [24:0] b);
        logic [50:0] p;
        p = 51'(a) * 51'(b) + 51'(ONE_Q24 >> 1);
        return p[48:24];
    endfunction

    logic [27:0] v;
    logic [56:0] dprod;
    logic [24:0] r_p1;
    logic        r_big1;
    logic [24:0] q;
    logic [24:0] r_q2, r_q_2;
    logic        r_big2;
    logic [24:0] r_q4, r_q_3;
    logic        r_big3;
    logic [24:0] q5;
    logic [25:0] rnd;
    logic [16:0] r_w;

    // p24/10 with rounding, through the reciprocal of ten
    assign v     = {i_x[19:0], 8'd0} + 28'd5;
    assign dprod = 57'(v) * 57'(RECIP10);
    assign q     = ONE_Q24 - r_p1;
    assign q5    = mul24(r_q4, r_q_3);
    assign rnd   = {1'b0, q5} + 26'd128;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= dprod[56:32];
            r_big1 <= i_x >= X_TEN;
            r_q2   <= mul24(q, q);
            r_q_2  <= q;
            r_big2 <= r_big1;
            r_q4   <= mul24(r_q2, r_q2);
            r_q_3  <= r_q_2;
            r_big3 <= r_big2;
            r_w    <= r_big3 ? 17'd0 : rnd[24:8];
        end
    end

    assign o_w = r_w;

endmodule

// ===== rtl/convective_weight_function.sv =====
// Convection weight A(|P|) for a cell-face Peclet magnitude (unsigned Q8.16 in, Q1.16 out,
// 65536 is 1.0). Each accepted beat yields exactly one result beat, in order; a new beat is
// taken on every clock while the output side takes results, and the whole pipeline freezes
// while a finished result waits. The depth comes from the 12-term series of the 2^-z unit (a
// multiply stage and a divide-by-k stage per term) followed by the 17-step divider that serves
// the exponential and rational schemes. The scheme register resets to power law and must only
// be written while no beat is in flight.

module convective_weight_function (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    cwf_pe_if.sink      i_pe,
    cwf_wt_if.source    o_wt
);
    import cwf_pkg::*;

    localparam int DEPTH = 47;

    t_scheme     r_scheme;
    logic        en;
    logic [DEPTH-1:0] r_v;
    logic [23:0] r_x [0:DEPTH-1];

    logic [31:0] p24a;
    logic [24:0] zc;
    logic [56:0] zprod;
    logic [37:0] r_z;
    logic [32:0] w_e;

    logic [47:0] r_sq;
    logic [47:0] kprod;
    logic [48:0] r_rden;

    logic [60:0] r_eprod;
    logic [32:0] r_eden;
    logic [33:0] pw_rnd;
    logic [16:0] r_pw [0:18];
    logic [17:0] r_dz;
    logic [31:0] p24f;

    logic [61:0] div_num;
    logic [48:0] div_den;
    logic [16:0] w_quo;
    logic        w_ovf;
    logic [16:0] w_pl;

    logic [23:0] xf;
    logic [24:0] hs;
    logic [16:0] lin;
    logic [16:0] qcl;
    logic [16:0] wsel;

    logic        r_out_valid;
    logic [16:0] r_weight;

    assign en         = !r_out_valid || o_wt.ready;
    assign i_pe.ready = en;
    assign o_wt.valid = r_out_valid;
    assign o_wt.weight = r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scheme <= SCHEME_RESET;
        end else if (i_cfg_we) begin
            r_scheme <= t_scheme'(i_cfg_wdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v         <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_v         <= {r_v[DEPTH-2:0], i_pe.valid};
            r_out_valid <= r_v[DEPTH-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x[0] <= i_pe.peclet_magnitude;
            for (int i = 1; i < DEPTH; i++) begin
                r_x[i] <= r_x[i-1];
            end
        end
    end

    // exponent argument: P*log2(e) or P*(-log2 0.553) in Q.32
    assign p24a  = {r_x[0], 8'd0};
    assign zc    = (r_scheme == SCH_POWER) ? NLOG2_0553 : LOG2E_Q24;
    assign zprod = 57'(p24a) * 57'(zc);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z <= zprod[53:16];
        end
    end

    cwf_exp2_neg u_exp2 (
        .i_clk (i_clk),
        .i_en  (en),
        .i_z   (r_z),
        .o_e   (w_e)
    );

    // rational denominator, timed to meet the exponential operands
    assign kprod = 48'(r_sq[47:16]) * 48'(K6712_Q16);
    assign p24f  = {r_x[27], 8'd0};
    assign pw_rnd = {1'b0, w_e} + 34'd32768;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq    <= 48'(r_x[26]) * 48'(r_x[26]);
            r_rden  <= 49'(ONE_Q32) + 49'(kprod);
            r_eprod <= 61'(p24f[27:0]) * 61'(w_e);
            r_eden  <= ONE_Q32 - w_e;
            r_pw[0] <= pw_rnd[32:16];
            for (int i = 1; i <= 18; i++) begin
                r_pw[i] <= r_pw[i-1];
            end
            r_dz <= {r_dz[16:0], r_eden == 33'd0};
        end
    end

    always_comb begin
        if (r_scheme == SCH_EXPONENTIAL) begin
            div_num = 62'(r_eprod) + (62'(r_eden) << 7);
            div_den = 49'(r_eden) << 8;
        end else begin
            div_num = (62'd1 << 48) + 62'(r_rden >> 1);
            div_den = r_rden;
        end
    end

    cwf_divider u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (div_num),
        .i_den (div_den),
        .o_quo (w_quo),
        .o_ovf (w_ovf)
    );

    cwf_power_law u_pl (
        .i_clk (i_clk),
        .i_en  (en),
        .i_x   (r_x[42]),
        .o_w   (w_pl)
    );

    // final selection on the last pipeline stage
    assign xf  = r_x[DEPTH-1];
    assign hs  = (25'(xf) + 25'd1) >> 1;
    assign lin = (hs >= 25'(ONE_OUT)) ? 17'd0 : 17'(25'(ONE_OUT) - hs);
    assign qcl = (w_ovf || w_quo > ONE_OUT) ? ONE_OUT : w_quo;

    always_comb begin
        unique case (r_scheme)
            SCH_CENTRAL:     wsel = (xf < X_ONE) ? lin : w_pl;
            SCH_UPWIND:      wsel = ONE_OUT;
            SCH_HYBRID:      wsel = lin;
            SCH_POWER_LAW:   wsel = w_pl;
            SCH_EXPONENTIAL: begin
                if (xf <= X_SMALL_MAX) begin
                    wsel = lin;
                end else if (xf >= X_TEN) begin
                    wsel = 17'd0;
                end else if (r_dz[17]) begin
                    wsel = ONE_OUT;
                end else begin
                    wsel = qcl;
                end
            end
            SCH_POWER:       wsel = (xf >= X_SIXTY4) ? 17'd0 : r_pw[18];
            SCH_ZERO, SCH_RATIONAL: wsel = w_quo;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_weight <= wsel;
        end
    end

`ifndef SYNTHESIS
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_weight <= ONE_OUT)
        else $error("weight above one");

    a_upwind_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_scheme == SCH_UPWIND) |-> r_weight == ONE_OUT)
        else $error("upwind weight not one");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_x[0]) && $stable(r_v)))
        else $error("pipeline moved during stall");
`endif

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for convective_weight_function, streams peclet beats
// under random gaps and stalls and checks every weight against a bit-exact predictor
// depends on cwf_pkg, cwf_pe_if, cwf_wt_if and the block itself
`timescale 1ns / 1ps

module tb_top;
    import cwf_pkg::*;

    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 60;

    class weight_scoreboard;
        t_scheme scheme;
        logic [16:0] pending[$];
        int errors;

        function new();
            scheme = SCHEME_RESET;
            errors = 0;
        endfunction

        function longint unsigned mul24(longint unsigned a, longint unsigned b);
            return (a * b + (64'd1 << 23)) >> 24;
        endfunction

        function longint unsigned half_ramp(longint unsigned p24);
            longint unsigned h;
            h = (p24 + 64'd256) >> 9;
            return (h >= 64'd65536) ? 64'd0 : 64'd65536 - h;
        endfunction

        function longint unsigned power_law(longint unsigned p24);
            longint unsigned q, q2, q4, q5;
            if (p24 >= 64'd10 << 24) return 0;
            q = (64'd1 << 24) - (p24 + 5) / 10;
            q2 = mul24(q, q);
            q4 = mul24(q2, q2);
            q5 = mul24(q4, q);
            return (q5 + 64'd128) >> 8;
        endfunction

        // 2^-z with z in Q.32, taylor series for the fractional part
        function longint unsigned pow2_neg(longint unsigned z);
            longint unsigned n, f, g, t, pos, neg;
            n = z >> 32;
            f = z & 64'hFFFF_FFFF;
            g = (f * 64'd2977044472) >> 32;
            t = 64'd1 << 32;
            pos = t;
            neg = 0;
            for (int k = 1; k <= 12; k++) begin
                t = ((t * g) >> 32) / k;
                if (k % 2) neg += t;
                else pos += t;
            end
            if (n >= 40) return 0;
            return (pos - neg) >> n;
        endfunction

        function longint unsigned expo(longint unsigned p24);
            longint unsigned e, d, r;
            if (100 * p24 < (64'd1 << 24)) return half_ramp(p24);
            if (p24 >= 64'd10 << 24) return 0;
            e = pow2_neg((p24 * 64'd24204406) >> 16);
            if (e == (64'd1 << 32)) return 65536;
            d = ((64'd1 << 32) - e) << 8;
            r = (p24 * e + d / 2) / d;
            return (r > 65536) ? 64'd65536 : r;
        endfunction

        function longint unsigned rational(longint unsigned p24);
            longint unsigned p16, den;
            if (p24 >= 64'd8192 << 24) return 0;
            p16 = p24 >> 8;
            den = (64'd1 << 32) + ((p16 * p16) >> 16) * 64'd43988;
            return ((64'd1 << 48) + den / 2) / den;
        endfunction

        function logic [16:0] weight_of(logic [23:0] x);
            longint unsigned p24, w;
            p24 = longint'(x) << 8;
            case (scheme)
                SCH_CENTRAL:     w = (p24 < (64'd1 << 24)) ? half_ramp(p24) : power_law(p24);
                SCH_UPWIND:      w = 65536;
                SCH_HYBRID:      w = half_ramp(p24);
                SCH_POWER_LAW:   w = power_law(p24);
                SCH_EXPONENTIAL: w = expo(p24);
                SCH_POWER: begin
                    if (p24 >= 64'd64 << 24) w = 0;
                    else w = (pow2_neg((p24 * 64'd14338624) >> 16) + 64'd32768) >> 16;
                end
                default:         w = rational(p24);
            endcase
            return w[16:0];
        endfunction

        function void note_beat(logic [23:0] x);
            pending.push_back(weight_of(x));
        endfunction

        function void check_weight(logic [16:0] w);
            logic [16:0] exp_w;
            if (pending.size() == 0) begin
                $error("weight beat %0d with nothing outstanding", w);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (w !== exp_w) begin
                $error("weight: expected %0d, actual %0d", exp_w, w);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_wdata;
    cwf_pe_if pe ();
    cwf_wt_if wt ();
    weight_scoreboard sb;
    int idle_cycles;
    bit no_gaps;

    convective_weight_function u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_pe       (pe.sink),
        .o_wt       (wt.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // accepted beats are sampled at the edge, before the nonblocking updates land
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pe.valid && pe.ready) || (wt.valid && wt.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (pe.valid && pe.ready)
                sb.note_beat(pe.peclet_magnitude);
            if (wt.valid && wt.ready)
                sb.check_weight(wt.weight);
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("convective_weight_function verification failed");
                $finish;
            end
        end
    end

    // sink stalls
    initial begin
        int stall;
        wt.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                wt.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            wt.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    task automatic send_beat(logic [23:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            pe.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pe.valid <= 1'b1;
        pe.peclet_magnitude <= x;
        @(posedge i_clk);
        while (!(pe.valid && pe.ready)) @(posedge i_clk);
    endtask

    task automatic settle();
        pe.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scheme(t_scheme s);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= s;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.scheme = s;
        @(posedge i_clk);
    endtask

    function logic [23:0] random_magnitude();
        case ($urandom_range(0, 7))
            0: return 24'($urandom_range(0, 655));
            1: return 24'($urandom_range(0, 65535));
            2, 3: return 24'($urandom_range(0, 655359));
            4: return 24'($urandom_range(655000, 4194303));
            5: return 24'($urandom_range(4194000, 4194400));
            6: return 24'(1 << $urandom_range(0, 23)) + 24'($urandom_range(0, 3));
            default: return 24'($urandom());
        endcase
    endfunction

    initial begin
        t_scheme order[10];
        logic [23:0] corners[$];
        corners = '{24'd0, 24'd1, 24'd654, 24'd655, 24'd656, 24'd65535, 24'd65536,
                    24'd65537, 24'd655359, 24'd655360, 24'd4194303, 24'd4194304,
                    24'hAAAAAA, 24'h555555, 24'hFFFFFF};
        order = '{SCH_POWER_LAW, SCH_CENTRAL, SCH_UPWIND, SCH_HYBRID, SCH_EXPONENTIAL,
                  SCH_RATIONAL, SCH_POWER, SCH_ZERO, SCH_EXPONENTIAL, SCH_POWER};
        sb = new();
        idle_cycles = 0;
        no_gaps = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        pe.valid = 1'b0;
        pe.peclet_magnitude = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // first phase runs on the reset scheme
        for (int ph = 0; ph < 10; ph++) begin
            if (ph > 0) write_scheme(order[ph]);
            no_gaps = (ph % 3 == 2);
            foreach (corners[i]) send_beat(corners[i]);
            for (int n = 0; n < 80; n++) begin
                if (ph == 4 && n == 40) begin
                    pe.valid <= 1'b0;
                    @(posedge i_clk);
                    while (sb.pending.size() != 0) @(posedge i_clk);
                end
                send_beat(random_magnitude());
            end
            settle();
        end
        if (sb.errors == 0)
            $display("convective_weight_function verification clean");
        else
            $display("convective_weight_function verification failed");
        $finish;
    end
endmodule
